// File: design/cbsd_pkg.sv
// ----------------------------------------------------------------------------
// cbsd_pkg: shared definitions for the console CPU bus with sprite DMA
// Operation and target codes, bus address constants and the record types
// that travel from the decode front end to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cbsd_pkg;

  // Default sizing handed to the top level
  localparam int RAM_BYTES_DEF   = 2048;
  localparam int CPU_DIVIDER_DEF = 3;

  // Transaction operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Decoded bus targets
  localparam logic [2:0] TGT_NONE  = 3'd0;
  localparam logic [2:0] TGT_RAM   = 3'd1;
  localparam logic [2:0] TGT_PPU   = 3'd2;
  localparam logic [2:0] TGT_CART  = 3'd3;
  localparam logic [2:0] TGT_PAD   = 3'd4;
  localparam logic [2:0] TGT_DMA   = 3'd5;
  localparam logic [2:0] TGT_AUDIO = 3'd6;

  // Bus map
  localparam logic [15:0] ADDR_RAM_END   = 16'h1FFF;
  localparam logic [15:0] ADDR_PPU_END   = 16'h3FFF;
  localparam logic [15:0] ADDR_APU_BASE  = 16'h4000;
  localparam logic [15:0] ADDR_APU_LAST  = 16'h4013;
  localparam logic [15:0] ADDR_OAM_DMA   = 16'h4014;
  localparam logic [15:0] ADDR_APU_STAT  = 16'h4015;
  localparam logic [15:0] ADDR_PAD_FIRST = 16'h4016;
  localparam logic [15:0] ADDR_PAD_SECND = 16'h4017;

  // Decoded transaction, before the RAM read data is known
  typedef struct packed {
    logic [2:0]  target;
    logic [2:0]  reg_index;
    logic        use_ram;      // read data comes from work RAM
    logic [7:0]  value;        // read data when not from work RAM
    logic        cpu_step;
    logic [15:0] dma_read_addr;
    logic        dma_reading;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic        nmi_pulse;
    logic        irq_pulse;
  } cbsd_item_t;

  // Finished result
  typedef struct packed {
    logic [2:0]  target;
    logic [2:0]  reg_index;
    logic [7:0]  read_data;
    logic        cpu_step;
    logic [15:0] dma_read_addr;
    logic        dma_reading;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        nmi_pulse;
    logic        irq_pulse;
  } cbsd_result_t;

  // Work RAM port requests from the front end
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [12:0] addr;         // bus address below the RAM mirror limit
    logic [7:0]  wr_data;
  } cbsd_ram_req_t;

endpackage : cbsd_pkg

`default_nettype wire

// File: design/console_cpu_bus_with_sprite_dma_unit.sv
// ----------------------------------------------------------------------------
// console_cpu_bus_with_sprite_dma_unit: CPU-side bus with sprite DMA
// Decodes CPU reads and writes over work RAM, PPU registers, cartridge,
// controllers, sprite DMA and audio, and sequences master clock ticks.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, op .. irq    | request
//   out     | out_valid, out_stall, target ..  | result
//
// One transaction per cycle while in_stall is low; each accepted transaction
// passes the middle stage (work RAM read), then the output register.
// After reset the work RAM clearing pass holds in_stall high until every
// entry is cleared.
// A stalled output keeps its result; the middle stage still drains into a
// free output register, so input stalls only when both are full or while the clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module console_cpu_bus_with_sprite_dma_unit #(
  parameter int RAM_BYTES   = cbsd_pkg::RAM_BYTES_DEF,
  parameter int CPU_DIVIDER = cbsd_pkg::CPU_DIVIDER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] addr,
  input  wire logic [7:0]  data,
  input  wire logic        cart_claims,
  input  wire logic [7:0]  ext_data,
  input  wire logic [7:0]  pad_first,
  input  wire logic [7:0]  pad_second,
  input  wire logic        ppu_nmi,
  input  wire logic        mapper_irq,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       target,
  output logic [2:0]       reg_index,
  output logic [7:0]       read_data,
  output logic             cpu_step,
  output logic [15:0]      dma_read_addr,
  output logic             dma_reading,
  output logic             oam_write,
  output logic [7:0]       oam_index,
  output logic [7:0]       oam_data,
  output logic             nmi_pulse,
  output logic             irq_pulse
);
  import cbsd_pkg::*;

  logic          fire;
  logic          ram_busy;
  logic [7:0]    ram_rd_data;
  cbsd_item_t    front_item;
  cbsd_ram_req_t ram_req;

  logic          mid_valid;
  cbsd_item_t    mid_item;
  logic          mid_adv;
  logic          out_load;
  cbsd_result_t  res, res_next;
  logic [7:0]    dma_byte;

  assign out_load = !out_valid || !out_stall;
  assign mid_adv  = mid_valid && out_load;
  assign in_stall = ram_busy || (mid_valid && !out_load);
  assign fire     = in_valid && !in_stall;

  cbsd_front #(
    .CPU_DIVIDER (CPU_DIVIDER)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .op          (op),
    .addr        (addr),
    .data        (data),
    .cart_claims (cart_claims),
    .ext_data    (ext_data),
    .pad_first   (pad_first),
    .pad_second  (pad_second),
    .ppu_nmi     (ppu_nmi),
    .mapper_irq  (mapper_irq),
    .item        (front_item),
    .ram_req     (ram_req)
  );

  cbsd_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (ram_rd_data),
    .busy    (ram_busy)
  );

  // Hold the decoded transaction while the RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (fire) begin
      mid_valid <= 1'b1;
    end else if (mid_adv) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mid_item <= front_item;
    end
  end

  // Merge the RAM data and the latched DMA byte into the result
  always_comb begin
    res_next.target        = mid_item.target;
    res_next.reg_index     = mid_item.reg_index;
    res_next.read_data     = mid_item.use_ram ? ram_rd_data : mid_item.value;
    res_next.cpu_step      = mid_item.cpu_step;
    res_next.dma_read_addr = mid_item.dma_read_addr;
    res_next.dma_reading   = mid_item.dma_reading;
    res_next.oam_write     = mid_item.oam_write;
    res_next.oam_index     = mid_item.oam_index;
    res_next.oam_data      = mid_item.oam_write ? dma_byte : 8'd0;
    res_next.nmi_pulse     = mid_item.nmi_pulse;
    res_next.irq_pulse     = mid_item.irq_pulse;
  end

  // Latch the byte fetched by a DMA source read
  always_ff @(posedge clk) begin
    if (rst) begin
      dma_byte <= 8'd0;
    end else if (mid_adv && mid_item.dma_reading) begin
      dma_byte <= res_next.read_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv) begin
      res <= res_next;
    end
  end

  assign target        = res.target;
  assign reg_index     = res.reg_index;
  assign read_data     = res.read_data;
  assign cpu_step      = res.cpu_step;
  assign dma_read_addr = res.dma_read_addr;
  assign dma_reading   = res.dma_reading;
  assign oam_write     = res.oam_write;
  assign oam_index     = res.oam_index;
  assign oam_data      = res.oam_data;
  assign nmi_pulse     = res.nmi_pulse;
  assign irq_pulse     = res.irq_pulse;

endmodule : console_cpu_bus_with_sprite_dma_unit

`default_nettype wire

// File: design/cbsd_ram.sv
// ----------------------------------------------------------------------------
// cbsd_ram: work RAM
// Single-port synchronous memory with registered read data. A clearing pass
// after reset zeroes every entry, one per cycle, while busy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cbsd_ram #(
  parameter int RAM_BYTES = cbsd_pkg::RAM_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cbsd_pkg::cbsd_ram_req_t req,
  output logic [7:0]                 rd_data,
  output logic                       busy
);
  import cbsd_pkg::*;

  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam logic [RAM_AW-1:0] LAST_ENTRY = RAM_AW'(RAM_BYTES - 1);

  logic [7:0]        mem [RAM_BYTES];
  logic [RAM_AW-1:0] clr_addr;
  logic [RAM_AW-1:0] addr;

  // Fold the mirrored bus address into the RAM: five conditional subtracts
  function automatic logic [RAM_AW-1:0] ram_fold(input logic [12:0] a);
    logic [17:0] r;
    r = 18'(a);
    for (int k = 4; k >= 0; k--) begin
      if (r >= (18'(RAM_BYTES) << k)) begin
        r = r - (18'(RAM_BYTES) << k);
      end
    end
    return r[RAM_AW-1:0];
  endfunction

  assign addr = ram_fold(req.addr);

  // Sweep the memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ENTRY) begin
        busy <= 1'b0;
      end
    end
  end

  // Write port: clear sweep or bus write
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 8'h00;
    end else if (req.wr_en) begin
      mem[addr] <= req.wr_data;
    end
  end

  // Read port: hold the last read data until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule : cbsd_ram

`default_nettype wire

// File: design/cbsd_front.sv
// ----------------------------------------------------------------------------
// cbsd_front: bus decode and sequencing state
// Decodes each transaction, drives the work RAM port and keeps the
// controller shift registers, the tick phase and the sprite DMA state.
// ----------------------------------------------------------------------------
`default_nettype none

module cbsd_front #(
  parameter int CPU_DIVIDER = cbsd_pkg::CPU_DIVIDER_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire logic [1:0]              op,
  input  wire logic [15:0]             addr,
  input  wire logic [7:0]              data,
  input  wire logic                    cart_claims,
  input  wire logic [7:0]              ext_data,
  input  wire logic [7:0]              pad_first,
  input  wire logic [7:0]              pad_second,
  input  wire logic                    ppu_nmi,
  input  wire logic                    mapper_irq,
  output cbsd_pkg::cbsd_item_t         item,
  output cbsd_pkg::cbsd_ram_req_t      ram_req
);
  import cbsd_pkg::*;

  localparam int PHASE_W = (2 * CPU_DIVIDER > 1) ? $clog2(2 * CPU_DIVIDER) : 1;
  localparam logic [PHASE_W-1:0] PHASE_MID  = PHASE_W'(CPU_DIVIDER);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(2 * CPU_DIVIDER - 1);

  logic [7:0]         pad0, pad0_next;
  logic [7:0]         pad1, pad1_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [7:0]         dma_page, dma_page_next;
  logic [7:0]         dma_offset, dma_offset_next;
  logic               dma_waiting, dma_waiting_next;
  logic               dma_active, dma_active_next;

  logic               cpu_slot;
  logic               odd;
  logic               dma_rd_tick;
  logic               do_read;
  logic [15:0]        rd_addr;
  logic               rd_claim;
  logic [15:0]        dma_addr;

  assign odd      = phase[0];
  assign cpu_slot = (phase == '0) || (phase == PHASE_MID);
  assign dma_addr = {dma_page, dma_offset};

  assign dma_rd_tick = (op == OP_TICK) && cpu_slot && dma_active && !dma_waiting && !odd;
  assign do_read     = (op == OP_READ) || dma_rd_tick;
  assign rd_addr     = (op == OP_READ) ? addr : dma_addr;
  assign rd_claim    = cart_claims;

  // Decode the transaction and compute the next state
  always_comb begin
    item             = '0;
    ram_req          = '0;
    pad0_next        = pad0;
    pad1_next        = pad1;
    phase_next       = phase;
    dma_page_next    = dma_page;
    dma_offset_next  = dma_offset;
    dma_waiting_next = dma_waiting;
    dma_active_next  = dma_active;

    // Read decode, shared by CPU reads and DMA source reads
    if (do_read) begin
      if (rd_claim) begin
        item.target = TGT_CART;
        item.value  = ext_data;
      end else if (rd_addr <= ADDR_RAM_END) begin
        item.target    = TGT_RAM;
        item.use_ram   = 1'b1;
        ram_req.rd_en  = 1'b1;
        ram_req.addr   = rd_addr[12:0];
      end else if (rd_addr <= ADDR_PPU_END) begin
        item.target    = TGT_PPU;
        item.reg_index = rd_addr[2:0];
        item.value     = ext_data;
      end else if (rd_addr == ADDR_APU_STAT) begin
        item.target = TGT_AUDIO;
      end else if (rd_addr == ADDR_PAD_FIRST) begin
        item.target = TGT_PAD;
        item.value  = {7'd0, pad0[7]};
        pad0_next   = {pad0[6:0], 1'b0};
      end else if (rd_addr == ADDR_PAD_SECND) begin
        item.target = TGT_PAD;
        item.value  = {7'd0, pad1[7]};
        pad1_next   = {pad1[6:0], 1'b0};
      end else begin
        item.target = TGT_NONE;
      end
    end

    // Write decode
    if (op == OP_WRITE) begin
      if (cart_claims) begin
        item.target = TGT_CART;
      end else if (addr <= ADDR_RAM_END) begin
        item.target     = TGT_RAM;
        ram_req.wr_en   = 1'b1;
        ram_req.addr    = addr[12:0];
        ram_req.wr_data = data;
      end else if (addr <= ADDR_PPU_END) begin
        item.target    = TGT_PPU;
        item.reg_index = addr[2:0];
      end else if ((addr >= ADDR_APU_BASE && addr <= ADDR_APU_LAST) ||
                   addr == ADDR_APU_STAT || addr == ADDR_PAD_SECND) begin
        item.target = TGT_AUDIO;
      end else if (addr == ADDR_OAM_DMA) begin
        item.target     = TGT_DMA;
        dma_page_next   = data;
        dma_offset_next = 8'd0;
        dma_active_next = 1'b1;
      end else if (addr == ADDR_PAD_FIRST) begin
        item.target = TGT_PAD;
        pad0_next   = pad_first;
        pad1_next   = pad_second;
      end else begin
        item.target = TGT_NONE;
      end
    end

    // Master clock tick: CPU cycle or DMA step, then interrupt forwarding
    if (op == OP_TICK) begin
      if (cpu_slot) begin
        if (dma_active) begin
          if (dma_waiting) begin
            if (odd) begin
              dma_waiting_next = 1'b0;
            end
          end else if (!odd) begin
            item.dma_reading   = 1'b1;
            item.dma_read_addr = dma_addr;
          end else begin
            item.oam_write  = 1'b1;
            item.oam_index  = dma_offset;
            dma_offset_next = dma_offset + 8'd1;
            if (dma_offset == 8'hFF) begin
              dma_active_next  = 1'b0;
              dma_waiting_next = 1'b1;
            end
          end
        end else begin
          item.cpu_step = 1'b1;
        end
      end
      item.nmi_pulse = ppu_nmi;
      item.irq_pulse = mapper_irq;
      phase_next     = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
    end

    // Drop the RAM request unless the transaction is taken
    ram_req.rd_en = ram_req.rd_en & fire;
    ram_req.wr_en = ram_req.wr_en & fire;
  end

  // Advance the state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      pad0        <= 8'd0;
      pad1        <= 8'd0;
      phase       <= '0;
      dma_page    <= 8'd0;
      dma_offset  <= 8'd0;
      dma_waiting <= 1'b1;
      dma_active  <= 1'b0;
    end else if (fire) begin
      pad0        <= pad0_next;
      pad1        <= pad1_next;
      phase       <= phase_next;
      dma_page    <= dma_page_next;
      dma_offset  <= dma_offset_next;
      dma_waiting <= dma_waiting_next;
      dma_active  <= dma_active_next;
    end
  end

endmodule : cbsd_front

`default_nettype wire
